// ===== src/spmq_pkg.sv =====
// ---------------------------------------------------------------------------
// Strict-priority multi-queue package
// Shared sizes, command codes and the item structures used across the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spmq_pkg;

  localparam int NUM_LEVELS  = 8;
  localparam int QUEUE_DEPTH = 1024;

  localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = $clog2(NUM_LEVELS * QUEUE_DEPTH);

  // Depth of the command queue between the front and back parts.
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  priority_req;
    logic [15:0] packet_handle;
  } in_item_t;

  typedef struct packed {
    logic        out_valid;
    logic [15:0] out_handle;
    logic [2:0]  out_priority;
    logic        dropped;
    logic [15:0] dropped_handle;
  } out_item_t;

  // A classified command as it waits in the queue.
  typedef struct packed {
    cmd_t             command;
    logic [LVL_W-1:0] level;
    logic [15:0]      handle;
  } fq_entry_t;

  // Status of the command queue, seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } fq_status_t;

endpackage

`default_nettype wire

// ===== src/spmq_front.sv =====
// ---------------------------------------------------------------------------
// Strict-priority multi-queue front end
// Accepts command beats, clamps the priority to a level and pushes them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spmq_front
  import spmq_pkg::*;
(
  input  wire        start,
  output logic       busy,
  input  in_item_t   in_item,
  input  fq_status_t fq_status,
  output logic       push,
  output fq_entry_t  push_entry
);

  assign busy = fq_status.full;
  assign push = start && !fq_status.full;

  always_comb begin
    push_entry.command = in_item.command;
    push_entry.handle  = in_item.packet_handle;
    if (32'(in_item.priority_req) > 32'(NUM_LEVELS - 1)) begin
      push_entry.level = LVL_W'(NUM_LEVELS - 1);
    end else begin
      push_entry.level = LVL_W'(in_item.priority_req);
    end
  end

endmodule

`default_nettype wire

// ===== src/spmq_queue.sv =====
// ---------------------------------------------------------------------------
// Strict-priority multi-queue command queue
// Short FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spmq_queue
  import spmq_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  fq_entry_t  push_entry,
  input  wire        pop,
  output fq_entry_t  head_entry,
  output fq_status_t fq_status
);

  fq_entry_t            slot_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CNT_W-1:0]  count_r, count_nxt;

  assign fq_status.full  = (count_r == FQ_CNT_W'(FQ_DEPTH));
  assign fq_status.empty = (count_r == '0);
  assign head_entry      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_status.full |-> !push)
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_status.empty |-> !pop)
    else $error("command queue read while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("command queue count did not follow a push");
`endif

endmodule

`default_nettype wire

// ===== src/spmq_back.sv =====
// ---------------------------------------------------------------------------
// Strict-priority multi-queue back end
// Holds the per-level pointers and the handle store and executes commands.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spmq_back
  import spmq_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  fq_status_t fq_status,
  input  fq_entry_t  head_entry,
  output logic       pop,
  output logic       out_strobe,
  output out_item_t  out_result
);

  logic [PTR_W-1:0] head_r [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] fill_r [NUM_LEVELS];
  logic [15:0]      store [NUM_LEVELS * QUEUE_DEPTH];

  logic [LVL_W-1:0] enc_lvl;
  logic             any_ne;
  logic [LVL_W-1:0] lvl_sel;
  logic             is_enq;
  logic             lvl_full;
  logic             upd_en;
  logic             wr_en;
  logic             rd_en;
  logic [ADDR_W-1:0] base_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PTR_W-1:0] head_nxt;
  logic [PTR_W-1:0] tail_nxt;
  logic [CNT_W-1:0] fill_nxt;

  logic [15:0]      rd_data_r;
  logic             res_strobe_r;
  logic             res_valid_r;
  logic [2:0]       res_prio_r;
  logic             res_dropped_r;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Highest non-empty level; later iterations override earlier ones.
  always_comb begin
    enc_lvl = '0;
    any_ne  = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill_r[i] != '0) begin
        enc_lvl = LVL_W'(i);
        any_ne  = 1'b1;
      end
    end
  end

  assign pop       = !fq_status.empty;
  assign is_enq    = (head_entry.command == CMD_ENQ);
  assign lvl_sel   = is_enq ? head_entry.level : enc_lvl;
  assign lvl_full  = (fill_r[lvl_sel] == CNT_W'(QUEUE_DEPTH));
  assign upd_en    = pop && (is_enq || any_ne);
  assign wr_en     = pop && is_enq;
  assign rd_en     = pop && ((is_enq && lvl_full) || (!is_enq && any_ne));
  assign base_addr = ADDR_W'(ADDR_W'(lvl_sel) * ADDR_W'(QUEUE_DEPTH));
  assign wr_addr   = base_addr + ADDR_W'(tail_r[lvl_sel]);
  assign rd_addr   = base_addr + ADDR_W'(head_r[lvl_sel]);

  always_comb begin
    head_nxt = head_r[lvl_sel];
    tail_nxt = tail_r[lvl_sel];
    fill_nxt = fill_r[lvl_sel];
    if (is_enq) begin
      tail_nxt = advance(tail_r[lvl_sel]);
      if (lvl_full) begin
        // The oldest entry is evicted, so the count stays at the depth.
        head_nxt = advance(head_r[lvl_sel]);
      end else begin
        fill_nxt = fill_r[lvl_sel] + 1'b1;
      end
    end else begin
      head_nxt = advance(head_r[lvl_sel]);
      fill_nxt = fill_r[lvl_sel] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        fill_r[i] <= '0;
      end
      res_strobe_r <= 1'b0;
    end else begin
      if (upd_en) begin
        head_r[lvl_sel] <= head_nxt;
        tail_r[lvl_sel] <= tail_nxt;
        fill_r[lvl_sel] <= fill_nxt;
      end
      res_strobe_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_valid_r   <= !is_enq && any_ne;
      res_prio_r    <= (!is_enq && any_ne) ? 3'(lvl_sel) : 3'd0;
      res_dropped_r <= is_enq && lvl_full;
    end
  end

  // Read-first store: on a full level the evicted entry is read at the slot
  // that the new handle overwrites in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= head_entry.handle;
    end
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

  assign out_strobe                = res_strobe_r;
  assign out_result.out_valid      = res_valid_r;
  assign out_result.out_handle     = res_valid_r ? rd_data_r : 16'd0;
  assign out_result.out_priority   = res_prio_r;
  assign out_result.dropped        = res_dropped_r;
  assign out_result.dropped_handle = res_dropped_r ? rd_data_r : 16'd0;

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (fill_r[lvl_sel] <= CNT_W'(QUEUE_DEPTH)))
    else $error("level fill count above queue depth");

  a_strobe_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_strobe)
    else $error("executed command produced no result beat");

  a_deq_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !is_enq && any_ne) |=> (out_result.out_valid && !out_result.dropped))
    else $error("dequeue of a non-empty scheduler returned no handle");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && is_enq && lvl_full) |=> out_result.dropped)
    else $error("enqueue on a full level did not report an eviction");
`endif

endmodule

`default_nettype wire

// ===== src/strict_priority_multi_queue_core.sv =====
// ---------------------------------------------------------------------------
// Strict-priority multi-queue scheduler
// Per-level FIFOs of packet handles with strict-priority dequeue.
// ---------------------------------------------------------------------------
// Usage:
//   A command beat (in_item) is taken on a rising edge with start high and
//   busy low. An enqueue clamps its priority to at most the top level and appends the
//   handle; a full level evicts its oldest handle, reported as dropped. A
//   dequeue pops the head of the highest non-empty level, or reports empty.
//   Every command gives exactly one result beat on out_result, marked by
//   out_strobe for one cycle; the receiver must take it then.
//   The accepted command is stored in the command queue; the back end pops it
//   from there and registers its result beat. Throughput: one command per
//   cycle while busy is low, as the back end pops the queue whenever it holds
//   an entry; a short command queue sits in front.
//   busy rises only when that queue is full.
//   Reset empties every level and the command queue; the handle store is not
//   cleared, as no entry is read before it has been written.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_multi_queue_core
  import spmq_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_result
);

  fq_status_t fq_status;
  fq_entry_t  push_entry;
  fq_entry_t  head_entry;
  logic       push;
  logic       pop;

  spmq_front u_front (
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .fq_status  (fq_status),
    .push       (push),
    .push_entry (push_entry)
  );

  spmq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .fq_status  (fq_status)
  );

  spmq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fq_status  (fq_status),
    .head_entry (head_entry),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

`default_nettype wire
